FILE: rtl/core/assert_macros.svh
// Concurrent assertion helpers; clock and active-low reset passed in.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define HWT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define HWT_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: rtl/core/hwt_pkg.sv
`default_nettype none
package hwt_pkg;

    localparam int SLOTS     = 10;
    localparam int MAX_TASKS = 16;
    localparam int PERIOD_W  = 16;
    localparam int ID_W      = 4;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TASK_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CMP_W     = 8;
    localparam int RECIP_SH  = PERIOD_W + SLOT_W;
    localparam int RECIP_W   = PERIOD_W + 1;
    localparam int PROD_W    = PERIOD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_SH) + SLOTS - 1) / SLOTS);

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ADD  = 2'd1,
        OP_DEL  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_FIRED      = 3'd0,
        ST_ADDED      = 3'd1,
        ST_DELETED    = 3'd2,
        ST_NOT_ARMED  = 3'd3,
        ST_BAD_PERIOD = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [ID_W-1:0]     task_id;
        logic [PERIOD_W-1:0] period_ticks;
    } t_in_item;

    typedef struct packed {
        logic [2:0]      status;
        logic [ID_W-1:0] task_id_res;
        logic            last;
    } t_out_item;

    typedef struct packed {
        logic                armed;
        logic [SLOT_W-1:0]   slot;
        logic [PERIOD_W-1:0] rounds;
        logic [PERIOD_W-1:0] pdiv;
        logic [SLOT_W-1:0]   pmod;
    } t_entry;

    typedef struct packed {
        logic                tick;
        logic                add;
        logic                del;
        logic                target;
        logic [SLOT_W-1:0]   cur;
        logic [PERIOD_W-1:0] quot;
        logic [SLOT_W-1:0]   pmod;
    } t_head_ctl;

    typedef struct packed {
        logic fire;
        logic was_armed;
    } t_head_res;

    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                   input logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (SLOT_W+1)'(SLOTS)) begin
            sum = sum - (SLOT_W+1)'(SLOTS);
        end
        return sum[SLOT_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/hwt_cell.sv
`default_nettype none
module hwt_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_shift,
    input  wire hwt_pkg::t_entry i_entry,
    output hwt_pkg::t_entry      o_entry
);
    import hwt_pkg::*;

    logic   r_armed;
    t_entry r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
        end else if (i_shift) begin
            r_armed <= i_entry.armed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_entry;
        end
    end

    always_comb begin
        o_entry       = r_data;
        o_entry.armed = r_armed;
    end

endmodule
`default_nettype wire

FILE: rtl/core/hwt_head.sv
`default_nettype none
module hwt_head (
    input  wire hwt_pkg::t_entry    i_entry,
    input  wire hwt_pkg::t_head_ctl i_ctl,
    output hwt_pkg::t_entry         o_entry,
    output hwt_pkg::t_head_res      o_res
);
    import hwt_pkg::*;

    always_comb begin
        o_entry         = i_entry;
        o_res.fire      = 1'b0;
        o_res.was_armed = i_entry.armed;
        if (i_ctl.tick && i_entry.armed && (i_entry.slot == i_ctl.cur)) begin
            if (i_entry.rounds == '0) begin
                o_res.fire     = 1'b1;
                o_entry.slot   = slot_add(i_ctl.cur, i_entry.pmod);
                o_entry.rounds = i_entry.pdiv;
            end else begin
                o_entry.rounds = i_entry.rounds - 1'b1;
            end
        end
        if (i_ctl.add && i_ctl.target) begin
            o_entry.armed  = 1'b1;
            o_entry.slot   = slot_add(i_ctl.cur, i_ctl.pmod);
            o_entry.rounds = i_ctl.quot;
            o_entry.pdiv   = i_ctl.quot;
            o_entry.pmod   = i_ctl.pmod;
        end
        if (i_ctl.del && i_ctl.target) begin
            o_entry.armed = 1'b0;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/hwt_div.sv
`default_nettype none
module hwt_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [hwt_pkg::PERIOD_W-1:0]    i_dividend,
    output logic                                 o_done,
    output logic [hwt_pkg::PERIOD_W-1:0]         o_quot,
    output logic [hwt_pkg::SLOT_W-1:0]           o_pmod
);
    import hwt_pkg::*;

    logic                r_stage;
    logic                r_done;
    logic [PERIOD_W-1:0] r_dvd;
    logic [PERIOD_W-1:0] r_quot;
    logic [SLOT_W-1:0]   r_pmod;
    logic [PROD_W-1:0]   prod;
    logic [PERIOD_W-1:0] rem_full;

    // divide by SLOTS through the reciprocal, then recover the remainder
    always_comb begin
        prod     = PROD_W'(i_dividend) * PROD_W'(RECIP);
        rem_full = r_dvd - PERIOD_W'(r_quot * SLOTS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= i_start;
            r_done  <= r_stage;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= i_dividend;
            r_quot <= PERIOD_W'(prod >> RECIP_SH);
        end
        if (r_stage) begin
            r_pmod <= slot_add(rem_full[SLOT_W-1:0], SLOT_W'(1));
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_pmod = r_pmod;

endmodule
`default_nettype wire

FILE: rtl/core/hashed_timer_wheel.sv
// Hashed timer wheel with per-task round counts.
// Input channel (i_in_valid / o_in_ready, i_in_item): tick, add or delete.
// Output channel (o_out_valid / i_out_ready, o_out_item): one status per add
// or delete, one fire item per task firing on a tick, last set on the final one.
// The task table is a ring of MAX_TASKS cells; every tick, delete or accepted add
// rotates the ring once, the head cell applying the update, so ids are visited in order.
// Steps from the accepting edge to the first item offered:
//   tick   : walk the ring, then a flush for the last fire.
//   delete : walk the ring, then the status item.
//   add    : divider (reciprocal multiply, then remainder), then walk the ring,
//            then a flush to the status item.
//   bad period / out of range add: straight to the status item.
// o_in_ready is low while an item is in work and rises in the cycle the final
// result is offered, so a new item is taken only once the last one is through.
// A fired task is held in a one-entry register until the next fire or the end of the
// walk decides its last flag; the walk stalls only when a second fire meets a
// full, stalled output register, and the flush waits for the output register.
// Reset (synchronous, active low) disarms all tasks and sets the current slot
// to zero; no clearing pass is needed.
`default_nettype none
module hashed_timer_wheel (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire hwt_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output hwt_pkg::t_out_item      o_out_item
);
    import hwt_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_WALK  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state              r_state;
    logic [1:0]          r_op;
    logic [ID_W-1:0]     r_id;
    logic [2:0]          r_status;
    logic [TASK_W-1:0]   r_step;
    logic [SLOT_W-1:0]   r_cur;
    logic                r_pend_valid;
    logic [ID_W-1:0]     r_pend_id;
    logic                r_out_valid;
    t_out_item           r_out_item;

    t_entry              chain [MAX_TASKS];
    t_entry              head_out;
    t_head_ctl           ctl;
    t_head_res           res;
    logic                accept;
    logic                out_free;
    logic                walking;
    logic                stall;
    logic                shift;
    logic                last_step;
    logic                div_start;
    logic                div_done;
    logic [PERIOD_W-1:0] div_quot;
    logic [SLOT_W-1:0]   div_pmod;
    logic [2:0]          add_status;
    logic                out_load;
    t_out_item           n_out_item;

    assign accept    = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign walking   = r_state == S_WALK;
    assign stall     = walking && res.fire && r_pend_valid && !out_free;
    assign shift     = walking && !stall;
    assign last_step = r_step == TASK_W'(MAX_TASKS - 1);

    always_comb begin
        if (CMP_W'(i_in_item.task_id) >= CMP_W'(MAX_TASKS)) begin
            add_status = ST_NOT_ARMED;
        end else if (i_in_item.period_ticks == '0) begin
            add_status = ST_BAD_PERIOD;
        end else begin
            add_status = ST_ADDED;
        end
    end

    assign div_start = accept && (i_in_item.opcode == OP_ADD) && (add_status == ST_ADDED);

    hwt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_in_item.period_ticks - 1'b1),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_pmod     (div_pmod)
    );

    always_comb begin
        ctl.tick   = r_op == OP_TICK;
        ctl.add    = r_op == OP_ADD;
        ctl.del    = r_op == OP_DEL;
        ctl.target = CMP_W'(r_step) == CMP_W'(r_id);
        ctl.cur    = r_cur;
        ctl.quot   = div_quot;
        ctl.pmod   = div_pmod;
    end

    hwt_head u_head (
        .i_entry (chain[0]),
        .i_ctl   (ctl),
        .o_entry (head_out),
        .o_res   (res)
    );

    for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
        if (k == MAX_TASKS - 1) begin : g_tail
            hwt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_entry (head_out),
                .o_entry (chain[k])
            );
        end else begin : g_mid
            hwt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_entry (chain[k+1]),
                .o_entry (chain[k])
            );
        end
    end

    always_comb begin
        out_load   = 1'b0;
        n_out_item = '{status: r_status, task_id_res: r_id, last: 1'b1};
        if (shift && res.fire && r_pend_valid) begin
            out_load   = 1'b1;
            n_out_item = '{status: ST_FIRED, task_id_res: r_pend_id, last: 1'b0};
        end else if (r_state == S_FLUSH && out_free) begin
            if (r_op == OP_TICK) begin
                out_load   = r_pend_valid;
                n_out_item = '{status: ST_FIRED, task_id_res: r_pend_id, last: 1'b1};
            end else begin
                out_load   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item <= n_out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cur        <= '0;
            r_step       <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op         <= i_in_item.opcode;
                        r_id         <= i_in_item.task_id;
                        r_step       <= '0;
                        r_pend_valid <= 1'b0;
                        case (i_in_item.opcode)
                            OP_TICK: begin
                                r_cur   <= slot_add(r_cur, SLOT_W'(1));
                                r_state <= S_WALK;
                            end
                            OP_ADD: begin
                                r_status <= add_status;
                                r_state  <= (add_status == ST_ADDED) ? S_DIV : S_FLUSH;
                            end
                            OP_DEL: begin
                                r_status <= ST_NOT_ARMED;
                                r_state  <= S_WALK;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (shift) begin
                        r_step <= last_step ? '0 : r_step + 1'b1;
                        if (res.fire) begin
                            r_pend_valid <= 1'b1;
                            r_pend_id    <= ID_W'(r_step);
                        end
                        if (ctl.del && ctl.target) begin
                            r_status <= res.was_armed ? ST_DELETED : ST_NOT_ARMED;
                        end
                        if (last_step) begin
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_FLUSH: begin
                    if (r_op == OP_TICK) begin
                        if (!r_pend_valid) begin
                            r_state <= S_IDLE;
                        end else if (out_free) begin
                            r_pend_valid <= 1'b0;
                            r_state      <= S_IDLE;
                        end
                    end else if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `HWT_ASSERT(a_pend_in_walk, i_clk, i_rst_n, r_pend_valid |-> (r_state == S_WALK || r_state == S_FLUSH), "held fire outside walk")
    `HWT_ASSERT(a_ring_home, i_clk, i_rst_n, (r_state == S_IDLE) |-> (r_step == '0), "ring not restored when idle")
    `HWT_ASSERT_NEVER(a_stall_full, i_clk, i_rst_n, stall && !r_out_valid, "walk stalled with empty output")
    `HWT_ASSERT(a_quiet_flush, i_clk, i_rst_n, (r_state == S_FLUSH && r_op == OP_TICK && !r_pend_valid) |=> (r_state == S_IDLE), "quiet tick did not finish")

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import hwt_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 300;
    localparam int CALM_ITEMS = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic      typed;
        t_out_item want;
        t_in_item  item;
    } t_plan_row;

    localparam t_out_item NO_RES = '0;
    localparam int PLAN_LEN = 25;
    localparam t_plan_row PLAN [PLAN_LEN] = '{
        '{1'b0, NO_RES, '{OP_TICK, 4'd0, 16'd0}},
        '{1'b1, '{ST_NOT_ARMED, 4'd0, 1'b1}, '{OP_DEL, 4'd0, 16'd0}},
        '{1'b1, '{ST_BAD_PERIOD, 4'd15, 1'b1}, '{OP_ADD, 4'd15, 16'd0}},
        '{1'b1, '{ST_ADDED, 4'd0, 1'b1}, '{OP_ADD, 4'd0, 16'd1}},
        '{1'b1, '{ST_ADDED, 4'd15, 1'b1}, '{OP_ADD, 4'd15, 16'd1}},
        '{1'b0, NO_RES, '{OP_TICK, 4'd0, 16'd0}},
        '{1'b1, '{ST_ADDED, 4'd15, 1'b1}, '{OP_ADD, 4'd15, 16'hFFFF}},
        '{1'b0, NO_RES, '{OP_TICK, 4'd0, 16'd0}},
        '{1'b1, '{ST_ADDED, 4'd5, 1'b1}, '{OP_ADD, 4'd5, 16'd10}},
        '{1'b1, '{ST_ADDED, 4'd6, 1'b1}, '{OP_ADD, 4'd6, 16'd11}},
        '{1'b1, '{ST_ADDED, 4'd9, 1'b1}, '{OP_ADD, 4'd9, 16'd2}},
        '{1'b0, NO_RES, '{OP_UNUSED, 4'd15, 16'hFFFF}},
        '{1'b1, '{ST_DELETED, 4'd15, 1'b1}, '{OP_DEL, 4'd15, 16'hFFFF}},
        '{1'b1, '{ST_NOT_ARMED, 4'd15, 1'b1}, '{OP_DEL, 4'd15, 16'd0}},
        '{1'b1, '{ST_ADDED, 4'd10, 1'b1}, '{OP_ADD, 4'd10, 16'd20}},
        '{1'b0, NO_RES, '{OP_TICK, 4'd0, 16'd0}},
        '{1'b0, NO_RES, '{OP_TICK, 4'd0, 16'd0}},
        '{1'b0, NO_RES, '{OP_TICK, 4'd0, 16'd0}},
        '{1'b0, NO_RES, '{OP_TICK, 4'd0, 16'd0}},
        '{1'b0, NO_RES, '{OP_TICK, 4'd0, 16'd0}},
        '{1'b0, NO_RES, '{OP_TICK, 4'd0, 16'd0}},
        '{1'b0, NO_RES, '{OP_TICK, 4'd0, 16'd0}},
        '{1'b0, NO_RES, '{OP_TICK, 4'd0, 16'd0}},
        '{1'b0, NO_RES, '{OP_TICK, 4'd0, 16'd0}},
        '{1'b0, NO_RES, '{OP_TICK, 4'd0, 16'd0}}
    };

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    logic [3:0]  wheel_cur;
    bit          wheel_armed [MAX_TASKS];
    logic [3:0]  wheel_slot [MAX_TASKS];
    logic [15:0] wheel_rounds [MAX_TASKS];
    logic [15:0] wheel_period [MAX_TASKS];

    t_out_item due_reports [$];
    t_out_item step_reports [$];
    t_out_item want_now;

    int  failures = 0;
    int  cycle_count = 0;
    bit  calm = 1'b0;
    bit  gaps_on = 1'b1;
    bit  stalls_on = 1'b1;
    int  holds_asked = 0;
    int  holds_taken = 0;
    int  hold_left = 0;
    int  stall_left = 0;

    hashed_timer_wheel uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void reschedule(input int id, input logic [15:0] period);
        wheel_slot[id] = 4'((int'(wheel_cur) + int'(period)) % SLOTS);
        wheel_rounds[id] = 16'((int'(period) - 1) / SLOTS);
        wheel_period[id] = period;
    endfunction

    function automatic t_out_item make_report(input t_status st, input int id, input bit lst);
        t_out_item r;
        r.status = st;
        r.task_id_res = 4'(id);
        r.last = lst;
        return r;
    endfunction

    function automatic void advance_wheel(input t_in_item it);
        bit [MAX_TASKS-1:0] fired;
        int top;
        int id;
        fired = '0;
        top = -1;
        id = int'(it.task_id);
        step_reports.delete();
        case (it.opcode)
            OP_TICK: begin
                wheel_cur = 4'((int'(wheel_cur) + 1) % SLOTS);
                for (int i = 0; i < MAX_TASKS; i++) begin
                    if (wheel_armed[i] && wheel_slot[i] == wheel_cur) begin
                        if (wheel_rounds[i] == 16'd0) begin
                            fired[i] = 1'b1;
                            top = i;
                            reschedule(i, wheel_period[i]);
                        end else begin
                            wheel_rounds[i] = wheel_rounds[i] - 16'd1;
                        end
                    end
                end
                for (int i = 0; i < MAX_TASKS; i++) begin
                    if (fired[i]) begin
                        step_reports = {step_reports, make_report(ST_FIRED, i, i == top)};
                    end
                end
            end
            OP_ADD: begin
                if (id >= MAX_TASKS) begin
                    step_reports = {step_reports, make_report(ST_NOT_ARMED, id, 1'b1)};
                end else if (it.period_ticks == 16'd0) begin
                    step_reports = {step_reports, make_report(ST_BAD_PERIOD, id, 1'b1)};
                end else begin
                    reschedule(id, it.period_ticks);
                    wheel_armed[id] = 1'b1;
                    step_reports = {step_reports, make_report(ST_ADDED, id, 1'b1)};
                end
            end
            OP_DEL: begin
                if (id < MAX_TASKS && wheel_armed[id]) begin
                    wheel_armed[id] = 1'b0;
                    step_reports = {step_reports, make_report(ST_DELETED, id, 1'b1)};
                end else begin
                    step_reports = {step_reports, make_report(ST_NOT_ARMED, id, 1'b1)};
                end
            end
            default: ;
        endcase
    endfunction

    task automatic offer(input t_in_item it, input logic typed, input t_out_item want);
        int gap;
        gap = 0;
        if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        advance_wheel(it);
        if (typed) begin
            due_reports = {due_reports, want};
        end else begin
            due_reports = {due_reports, step_reports};
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (due_reports.size() != 0);
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (holds_taken != holds_asked) begin
            holds_taken = holds_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!calm && stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 10);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
        if ($urandom_range(0, 199) == 0) begin
            stalls_on = !stalls_on;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_reports.size() == 0) begin
                $error("unexpected item: status %0d, task_id_res %0d, last %0d",
                       o_out_item.status, o_out_item.task_id_res, o_out_item.last);
                failures++;
            end else begin
                want_now = due_reports.pop_front();
                if (o_out_item.status !== want_now.status) begin
                    $error("status: expected %0d, got %0d",
                           want_now.status, o_out_item.status);
                    failures++;
                end
                if (o_out_item.task_id_res !== want_now.task_id_res) begin
                    $error("task_id_res: expected %0d, got %0d",
                           want_now.task_id_res, o_out_item.task_id_res);
                    failures++;
                end
                if (o_out_item.last !== want_now.last) begin
                    $error("last: expected %0d, got %0d", want_now.last, o_out_item.last);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_in_item it;
        int count;
        int pick;
        wheel_cur = '0;
        foreach (wheel_armed[i]) begin
            wheel_armed[i] = 1'b0;
            wheel_slot[i] = '0;
            wheel_rounds[i] = '0;
            wheel_period[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PLAN_LEN; r++) begin
            offer(PLAN[r].item, PLAN[r].typed, PLAN[r].want);
        end
        drain_results();

        // arm tasks 0 to 7 with period-1, then hold the output off
        gaps_on = 1'b0;
        for (int i = 0; i < 8; i++) begin
            it.opcode = OP_ADD;
            it.task_id = 4'(i);
            it.period_ticks = 16'd1;
            offer(it, 1'b0, NO_RES);
        end
        holds_asked++;
        for (int i = 0; i < 12; i++) begin
            it = '{OP_TICK, 4'd0, 16'd0};
            offer(it, 1'b0, NO_RES);
        end
        drain_results();

        count = 0;
        while (count < RANDOM_ITEMS) begin
            calm = (count >= RANDOM_ITEMS - CALM_ITEMS);
            if ($urandom_range(0, 39) == 0) begin
                gaps_on = !gaps_on;
            end
            it.task_id = 4'($urandom_range(0, 15));
            it.period_ticks = 16'($urandom());
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                it.opcode = OP_TICK;
            end else if (pick < 75) begin
                it.opcode = OP_ADD;
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    it.period_ticks = 16'd0;
                end else if (pick < 70) begin
                    it.period_ticks = 16'($urandom_range(1, 25));
                end else if (pick < 90) begin
                    it.period_ticks = 16'($urandom_range(26, 300));
                end
            end else if (pick < 93) begin
                it.opcode = OP_DEL;
            end else begin
                it.opcode = OP_UNUSED;
            end
            offer(it, 1'b0, NO_RES);
            if (it.opcode != OP_UNUSED) begin
                count++;
                if (count % 100 == 0) begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
